FILE: hw/rtl/vacd_pkg.sv
package vacd_pkg;

	// Address width and cache geometry
	localparam int ADDR_BITS  = 32;
	localparam int NEAR_SLOTS = 4;
	localparam int SAME_SETS  = 3;

	// Same table is kept as 256 rows (address low byte), one column per set
	localparam int SAME_ROWS  = 256;
	localparam int ROW_W      = $clog2(SAME_ROWS);
	localparam int NEAR_IDX_W = (NEAR_SLOTS > 1) ? $clog2(NEAR_SLOTS) : 1;
	localparam int SET_W      = (SAME_SETS > 1) ? $clog2(SAME_SETS) : 1;

	// Set of a recorded address: (address >> 8) mod SAME_SETS, by reciprocal
	localparam int QW = ADDR_BITS - ROW_W;
	localparam logic [QW:0] MOD_MUL = (QW + 1)'((64'd1 << QW) / SAME_SETS);
	// residue before correction lies in [0, 2*SAME_SETS)
	localparam int RW = $clog2(2 * SAME_SETS) + 1;

	// Address modes, compared on a widened mode value
	localparam int MODE_W  = 4;
	localparam int MODE_XW = 6;
	localparam logic [MODE_XW-1:0] MODE_SELF    = MODE_XW'(0);
	localparam logic [MODE_XW-1:0] MODE_HERE    = MODE_XW'(1);
	localparam logic [MODE_XW-1:0] MODE_NEAR_LO = MODE_XW'(2);
	localparam logic [MODE_XW-1:0] MODE_SAME_LO = MODE_XW'(2 + NEAR_SLOTS);
	localparam logic [MODE_XW-1:0] MODE_SAME_HI = MODE_XW'(2 + NEAR_SLOTS + SAME_SETS);

	// Item operations
	localparam logic OP_DECODE = 1'b0;
	localparam logic OP_CLEAR  = 1'b1;

	typedef struct packed {
		logic              op;
		logic [MODE_W-1:0] mode;
		logic [31:0]       operand;
		logic [31:0]       target_position;
	} in_item_t;

	typedef struct packed {
		logic [31:0] address;
		logic        error;
	} out_item_t;

	// Controller to datapath commands
	typedef struct packed {
		logic capture;
		logic calc;
		logic mul;
		logic commit;
	} cmd_t;

	typedef logic [SAME_SETS-1:0][ADDR_BITS-1:0] same_row_t;

endpackage

FILE: hw/rtl/vacd_ctrl.sv
module vacd_ctrl
	import vacd_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_stall,
	output logic out_valid,
	input  logic out_stall,
	output cmd_t cmd
);

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_CALC = 2'd1;
	localparam logic [1:0] ST_MUL  = 2'd2;
	localparam logic [1:0] ST_WR   = 2'd3;

	logic [1:0] state_q;
	logic [1:0] state_nxt;
	logic       out_valid_q;

	// Commands; commit waits for the output register to free up
	always_comb begin
		cmd.capture = (state_q == ST_IDLE) && in_valid;
		cmd.calc    = (state_q == ST_CALC);
		cmd.mul     = (state_q == ST_MUL);
		cmd.commit  = (state_q == ST_WR) && (!out_valid_q || !out_stall);
	end

	// Next state
	always_comb begin
		state_nxt = state_q;
		case (state_q)
			ST_IDLE: begin
				if (in_valid) state_nxt = ST_CALC;
			end
			ST_CALC: state_nxt = ST_MUL;
			ST_MUL:  state_nxt = ST_WR;
			ST_WR: begin
				if (cmd.commit) state_nxt = ST_IDLE;
			end
			default: state_nxt = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_nxt;
			if (cmd.commit) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign in_stall  = (state_q != ST_IDLE);
	assign out_valid = out_valid_q;

endmodule

FILE: hw/rtl/vacd_datapath.sv
module vacd_datapath
	import vacd_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [31:0] cfg_wdata,
	input  in_item_t    in_data,
	input  cmd_t        cmd,
	output out_item_t   out_data
);

	logic [31:0]           source_length_q;

	// Captured item
	logic                  op_s1;
	logic [MODE_W-1:0]     mode_s1;
	logic [31:0]           operand_s1;
	logic [32:0]           here_s1;
	same_row_t             row_s1;
	logic                  row_vld_s1;

	// Decoded address and set computation
	logic [ADDR_BITS-1:0]  addr_q;
	logic                  err_q;
	logic [2*QW:0]         prod_q;

	// Caches
	logic [ADDR_BITS-1:0]  near_ring_q [NEAR_SLOTS];
	logic [NEAR_IDX_W-1:0] near_slot_q;
	logic [SAME_ROWS-1:0]  row_vld_q;
	same_row_t             same_mem [SAME_ROWS];

	out_item_t             out_data_q;

	// Combinational
	logic [MODE_XW-1:0]    mode_x;
	logic [NEAR_IDX_W-1:0] near_idx;
	logic [SET_W-1:0]      rd_set;
	logic [ADDR_BITS-1:0]  addr_nxt;
	logic                  err_nxt;
	logic [2*QW:0]         prod;
	logic [QW-1:0]         quot;
	logic [RW-1:0]         qc_lo;
	logic [RW-1:0]         res0;
	logic [RW-1:0]         res;
	logic [SET_W-1:0]      wr_set;
	logic [ROW_W-1:0]      wr_row;

	// Source length register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			source_length_q <= '0;
		end else if (cfg_we) begin
			source_length_q <= cfg_wdata;
		end
	end

	// Capture item, precompute here base, read same-table row
	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			op_s1      <= in_data.op;
			mode_s1    <= in_data.mode;
			operand_s1 <= in_data.operand;
			here_s1    <= {1'b0, source_length_q} + {1'b0, in_data.target_position};
			row_s1     <= same_mem[in_data.operand[ROW_W-1:0]];
			row_vld_s1 <= row_vld_q[in_data.operand[ROW_W-1:0]];
		end
	end

	// Address decode per mode
	always_comb begin
		mode_x   = {{(MODE_XW - MODE_W){1'b0}}, mode_s1};
		near_idx = NEAR_IDX_W'(mode_x - MODE_NEAR_LO);
		rd_set   = SET_W'(mode_x - MODE_SAME_LO);
		addr_nxt = '0;
		err_nxt  = 1'b0;
		if (mode_x == MODE_SELF) begin
			addr_nxt = ADDR_BITS'(operand_s1);
		end else if (mode_x == MODE_HERE) begin
			if ({1'b0, operand_s1} > here_s1) begin
				err_nxt = 1'b1;
			end else begin
				addr_nxt = ADDR_BITS'(here_s1 - {1'b0, operand_s1});
			end
		end else if (mode_x < MODE_SAME_LO) begin
			addr_nxt = near_ring_q[near_idx] + ADDR_BITS'(operand_s1);
		end else if (mode_x < MODE_SAME_HI) begin
			addr_nxt = row_vld_s1 ? row_s1[rd_set] : '0;
		end else begin
			err_nxt = 1'b1;
		end
	end

	// Quotient estimate of (address >> 8) / SAME_SETS
	assign prod = {{(QW + 1){1'b0}}, addr_q[ADDR_BITS-1:ROW_W]} * {{QW{1'b0}}, MOD_MUL};

	always_ff @(posedge clk) begin
		if (cmd.calc) begin
			addr_q <= addr_nxt;
			err_q  <= err_nxt;
		end
		if (cmd.mul) begin
			prod_q <= prod;
		end
	end

	// Residue: estimate is low by at most one, so one correction step
	always_comb begin
		quot   = prod_q[2*QW-1:QW];
		qc_lo  = RW'(quot[RW-1:0] * RW'(SAME_SETS));
		res0   = addr_q[ROW_W +: RW] - qc_lo;
		res    = (res0 >= RW'(SAME_SETS)) ? (res0 - RW'(SAME_SETS)) : res0;
		wr_set = SET_W'(res);
		wr_row = addr_q[ROW_W-1:0];
	end

	// Near ring and row valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NEAR_SLOTS; i++) near_ring_q[i] <= '0;
			near_slot_q <= '0;
			row_vld_q   <= '0;
		end else if (cmd.commit) begin
			if (op_s1 == OP_CLEAR) begin
				for (int i = 0; i < NEAR_SLOTS; i++) near_ring_q[i] <= '0;
				near_slot_q <= '0;
				row_vld_q   <= '0;
			end else if (!err_q) begin
				near_ring_q[near_slot_q] <= addr_q;
				near_slot_q <= (near_slot_q == NEAR_IDX_W'(NEAR_SLOTS - 1)) ?
					'0 : near_slot_q + 1'b1;
				row_vld_q[wr_row] <= 1'b1;
			end
		end
	end

	// Same table write; a stale row gets its other columns zeroed
	always_ff @(posedge clk) begin
		if (cmd.commit && (op_s1 == OP_DECODE) && !err_q) begin
			for (int j = 0; j < SAME_SETS; j++) begin
				if (SET_W'(j) == wr_set) begin
					same_mem[wr_row][j] <= addr_q;
				end else if (!row_vld_q[wr_row]) begin
					same_mem[wr_row][j] <= '0;
				end
			end
		end
	end

	// Output register
	always_ff @(posedge clk) begin
		if (cmd.commit) begin
			if (op_s1 == OP_CLEAR || err_q) begin
				out_data_q.address <= '0;
			end else begin
				out_data_q.address <= 32'(addr_q);
			end
			out_data_q.error <= (op_s1 == OP_DECODE) && err_q;
		end
	end

	assign out_data = out_data_q;

endmodule

FILE: hw/rtl/vcdiff_address_cache_decoder_top.sv
// Channel  Direction  Handshake            Beat
// in       input      in_valid / in_stall   op, mode, operand, target_position
// out      output     out_valid/out_stall   address, error
// cfg      input      cfg_we                source_length (cfg_wdata)
//
// Items are taken one at a time: same-table row read at accept, address decode,
// set multiply, then cache/table write with the result into the output register.
// The same table is a single-port 256-row memory, one column per set; row valid
// bits make reset and clear items take effect at once, with no clearing pass.
// A result waiting on out_stall holds the item in its write cycle; the output
// register lets the next item be accepted while the previous beat waits.
module vcdiff_address_cache_decoder_top
	import vacd_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [31:0] cfg_wdata,
	input  logic        in_valid,
	output logic        in_stall,
	input  in_item_t    in_data,
	output logic        out_valid,
	input  logic        out_stall,
	output out_item_t   out_data
);

	cmd_t cmd;

	vacd_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.cmd       (cmd)
	);

	vacd_datapath u_datapath (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.in_data   (in_data),
		.cmd       (cmd),
		.out_data  (out_data)
	);

endmodule

FILE: tb/tb_top.sv
`timescale 1ns / 1ps

module tb_top
	import vacd_pkg::*;
;

	localparam int SAME_DEPTH = SAME_SETS * SAME_ROWS;

	typedef logic [ADDR_BITS-1:0] addr_t;

	// Address-cache predictor plus the queue of decoded beats still owed by the block
	class addr_cache_scoreboard;
		logic [31:0] src_len;
		addr_t       near_ring[NEAR_SLOTS];
		int unsigned near_ptr;
		addr_t       same_mem[SAME_DEPTH];
		out_item_t   expected_beats[$];
		int          errors;

		function new();
			src_len = '0;
			errors  = 0;
			flush_caches();
		endfunction

		function void flush_caches();
			foreach (near_ring[i])
				near_ring[i] = '0;
			foreach (same_mem[i])
				same_mem[i] = '0;
			near_ptr = 0;
		endfunction

		task report_mismatch(string msg);
			$display("mismatch at %0t: %s", $realtime, msg);
			errors++;
		endtask

		function int pending();
			return expected_beats.size();
		endfunction

		// Decode one accepted beat and queue the result it must produce
		function void note_input(in_item_t it);
			logic [MODE_XW-1:0] m;
			logic [63:0]        here;
			addr_t              a;
			logic               bad;
			out_item_t          res;
			m   = MODE_XW'(it.mode);
			a   = '0;
			bad = 1'b0;
			res = '0;
			if (it.op == OP_CLEAR) begin
				flush_caches();
				expected_beats.push_back(res);
				return;
			end
			if (m == MODE_SELF) begin
				a = addr_t'(it.operand);
			end else if (m == MODE_HERE) begin
				here = 64'(src_len) + 64'(it.target_position);
				if (64'(it.operand) > here)
					bad = 1'b1;
				else
					a = addr_t'(here - 64'(it.operand));
			end else if (m < MODE_SAME_LO) begin
				a = near_ring[int'(m - MODE_NEAR_LO)] + addr_t'(it.operand);
			end else if (m < MODE_SAME_HI) begin
				a = same_mem[int'(m - MODE_SAME_LO) * SAME_ROWS + int'(it.operand[7:0])];
			end else begin
				bad = 1'b1;
			end
			if (bad) begin
				res.error = 1'b1;
			end else begin
				// record in round-robin near slot and direct-mapped same entry
				near_ring[near_ptr] = a;
				near_ptr = (near_ptr + 1) % NEAR_SLOTS;
				same_mem[int'(a % SAME_DEPTH)] = a;
				res.address = 32'(a);
			end
			expected_beats.push_back(res);
		endfunction

		task check_beat(out_item_t got);
			out_item_t exp;
			if (expected_beats.size() == 0) begin
				report_mismatch($sformatf("unexpected beat addr=%h err=%b",
					got.address, got.error));
				return;
			end
			exp = expected_beats.pop_front();
			if (got.address !== exp.address)
				report_mismatch($sformatf("address got %h want %h", got.address, exp.address));
			if (got.error !== exp.error)
				report_mismatch($sformatf("error got %b want %b", got.error, exp.error));
		endtask
	endclass

	logic        clk;
	logic        arst_n;
	logic        cfg_we;
	logic [31:0] cfg_wdata;
	logic        in_valid;
	logic        in_stall;
	in_item_t    in_data;
	logic        out_valid;
	logic        out_stall;
	out_item_t   out_data;

	addr_cache_scoreboard sb = new();

	// idle percentages per side, changed per phase
	int unsigned gap_pct;
	int unsigned stall_pct;

	vcdiff_address_cache_decoder_top DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_data  (out_data)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Watch both channels; pre-edge values are seen here
	always @(posedge clk) begin
		if (arst_n) begin
			if (in_valid && !in_stall)
				sb.note_input(in_data);
			if (out_valid && !out_stall)
				sb.check_beat(out_data);
		end
	end

	// Receiver back-pressure in short bursts
	initial begin
		out_stall <= 1'b0;
		forever begin
			@(posedge clk);
			if (stall_pct != 0 && $urandom_range(0, 99) < stall_pct) begin
				out_stall <= 1'b1;
				repeat ($urandom_range(1, 4)) @(posedge clk);
				out_stall <= 1'b0;
			end
		end
	end

	initial begin
		#5_000_000;
		$display("TB_ERROR");
		$finish;
	end

	function automatic in_item_t mk_item(logic op, logic [MODE_XW-1:0] mode,
			logic [31:0] operand, logic [31:0] pos);
		in_item_t it;
		it.op              = op;
		it.mode            = MODE_W'(mode);
		it.operand         = operand;
		it.target_position = pos;
		return it;
	endfunction

	// Present one beat, with an optional gap ahead of it, and hold until taken
	task automatic send_item(in_item_t it);
		if (gap_pct != 0 && $urandom_range(0, 99) < gap_pct) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 4)) @(posedge clk);
		end
		in_valid <= 1'b1;
		in_data  <= it;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		@(posedge clk);
		while (sb.pending() != 0)
			@(posedge clk);
	endtask

	task automatic write_source_length(logic [31:0] v);
		cfg_we    <= 1'b1;
		cfg_wdata <= v;
		@(posedge clk);
		sb.src_len = v;
		cfg_we    <= 1'b0;
	endtask

	initial begin
		in_item_t    it;
		in_item_t    directed[$];
		logic [31:0] seen[$];
		logic [31:0] pos;
		logic [31:0] sl;
		logic [63:0] here;
		addr_t       a;
		int          r;
		int          k;

		arst_n    <= 1'b0;
		cfg_we    <= 1'b0;
		cfg_wdata <= '0;
		in_valid  <= 1'b0;
		in_data   <= '0;
		gap_pct   = 0;
		stall_pct = 0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: field extremes, every mode, wide sums, errors, clear
		write_source_length(32'hFFFF_FFFF);
		directed.push_back(mk_item(OP_DECODE, MODE_SELF, 32'hFFFF_FFFF, 32'h0));
		directed.push_back(mk_item(OP_DECODE, MODE_SELF, 32'h0, 32'hFFFF_FFFF));
		directed.push_back(mk_item(OP_DECODE, MODE_HERE, 32'h0, 32'hFFFF_FFFF));
		directed.push_back(mk_item(OP_DECODE, MODE_HERE, 32'hFFFF_FFFF, 32'hFFFF_FFFF));
		for (k = 0; k < NEAR_SLOTS; k++)
			directed.push_back(mk_item(OP_DECODE, MODE_XW'(MODE_NEAR_LO + k),
				(k % 2) ? 32'hFFFF_FFFF : 32'h1, 32'h10));
		directed.push_back(mk_item(OP_DECODE, MODE_SAME_LO, 32'h0000_00FF, 32'h20));
		directed.push_back(mk_item(OP_DECODE, MODE_XW'(MODE_SAME_LO + 1), 32'hFFFF_FFFE,
			32'h20));
		directed.push_back(mk_item(OP_DECODE, MODE_XW'(MODE_SAME_HI - 1), 32'hFFFF_FF00,
			32'h20));
		directed.push_back(mk_item(OP_DECODE, MODE_SAME_HI, 32'h5, 32'h30));
		directed.push_back(mk_item(OP_DECODE, '1, 32'hFFFF_FFFF, 32'hFFFF_FFFF));
		directed.push_back(mk_item(OP_CLEAR, '1, 32'hFFFF_FFFF, 32'hFFFF_FFFF));
		directed.push_back(mk_item(OP_DECODE, MODE_NEAR_LO, 32'h0, 32'h0));
		directed.push_back(mk_item(OP_DECODE, MODE_XW'(MODE_SAME_LO + 2), 32'hFF, 32'h0));
		foreach (directed[i])
			send_item(directed[i]);
		drain();

		write_source_length(32'h0);
		directed.delete();
		directed.push_back(mk_item(OP_DECODE, MODE_HERE, 32'h1, 32'h0));
		directed.push_back(mk_item(OP_DECODE, MODE_HERE, 32'h0, 32'h0));
		directed.push_back(mk_item(OP_DECODE, MODE_HERE, 32'h5, 32'h5));
		directed.push_back(mk_item(OP_DECODE, MODE_HERE, 32'h8000_0000, 32'h7FFF_FFFF));
		directed.push_back(mk_item(OP_DECODE, MODE_SAME_LO, 32'h0, 32'h6));
		directed.push_back(mk_item(OP_CLEAR, MODE_SELF, 32'h0, 32'h0));
		foreach (directed[i])
			send_item(directed[i]);
		drain();

		// Random windows: mostly well-formed decodes, some noise and clears
		pos = $urandom_range(0, 4095);
		for (int ph = 0; ph < 8; ph++) begin
			case (ph)
				0: sl = 32'h0;
				1: sl = 32'hFFFF_FFFF;
				2: sl = $urandom_range(1, 255);
				3: sl = 32'h8000_0000;
				default: sl = $urandom;
			endcase
			write_source_length(sl);
			if (ph == 7) begin
				gap_pct   = 0;
				stall_pct = 0;
			end else begin
				gap_pct   = (ph % 3 == 1) ? 0 : $urandom_range(10, 40);
				stall_pct = (ph % 3 == 2) ? 0 : $urandom_range(10, 40);
			end
			for (int n = 0; n < 240; n++) begin
				r = $urandom_range(0, 99);
				if (r < 3) begin
					// new window
					it = mk_item(OP_CLEAR, MODE_XW'($urandom_range(0, 15)), $urandom, $urandom);
					seen.delete();
					pos = ($urandom_range(0, 9) < 7) ? $urandom_range(0, 4095) : $urandom;
				end else if (r < 10) begin
					it = mk_item(OP_DECODE, MODE_XW'($urandom_range(0, 15)), $urandom, $urandom);
				end else begin
					it = mk_item(OP_DECODE, MODE_XW'($urandom_range(0, MODE_SAME_HI - 1)), 0, pos);
					case (MODE_XW'(it.mode)) inside
						MODE_SELF: begin
							it.operand = ($urandom_range(0, 1)) ? $urandom : $urandom_range(0, 65535);
							seen.push_back(it.operand);
							if (seen.size() > 32)
								void'(seen.pop_front());
						end
						MODE_HERE: begin
							here = 64'(sl) + 64'(pos);
							it.operand = 32'({$urandom, $urandom} % (here + 64'd1));
						end
						[MODE_NEAR_LO : MODE_SAME_LO - 1]: begin
							it.operand = ($urandom_range(0, 1)) ? $urandom : $urandom_range(0, 1023);
						end
						default: begin
							// aim at an entry a self decode filled
							if (seen.size() != 0 && $urandom_range(0, 9) < 7) begin
								a = addr_t'(seen[$urandom_range(0, seen.size() - 1)]);
								it.mode = MODE_W'(MODE_SAME_LO + (a % SAME_DEPTH) / SAME_ROWS);
								it.operand = {24'($urandom_range(0, 32'h00FF_FFFF)), 8'(a)};
							end else begin
								it.operand = $urandom;
							end
						end
					endcase
					pos = pos + $urandom_range(1, 48);
				end
				send_item(it);
			end
			drain();
		end

		repeat (8) @(posedge clk);
		if (sb.errors == 0 && sb.pending() == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

endmodule
